// ===== rtl/hid_key_report_builder_core_defines.svh =====
// ----------------------------------------------------------------------------
// HID key report builder: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HID_KEY_REPORT_BUILDER_CORE_DEFINES_SVH
`define HID_KEY_REPORT_BUILDER_CORE_DEFINES_SVH

// Check that a condition leads to a consequence in the next cycle, outside reset.
`define HKRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkrb checker: next-cycle property failed");

// Same form, also checked while reset is asserted.
`define HKRB_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hkrb checker: next-cycle property failed");

`endif

// ===== rtl/hkrb_pkg.sv =====
// ----------------------------------------------------------------------------
// HID key report builder package
// Sizes, event codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  localparam int ROLLOVER_SLOTS  = 6;
  localparam int NKRO_KEYS       = 120;
  localparam int NKRO_BITS       = 120;
  localparam int BITMAP_HALF     = 60;
  localparam int BOOT_MAX_SLOTS  = 6;
  localparam int BOOT_EMIT_SLOTS = (ROLLOVER_SLOTS < BOOT_MAX_SLOTS) ?
                                   ROLLOVER_SLOTS : BOOT_MAX_SLOTS;
  localparam int NKRO_LIMIT      = (NKRO_KEYS < NKRO_BITS) ? NKRO_KEYS : NKRO_BITS;

  localparam int FUNC_W    = 2;
  localparam int CODE_W    = 8;
  localparam int BOOT_W    = 64;
  localparam int MODS_W    = 8;
  localparam int HALF_W    = 60;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd2;

  // Modifier usages 0xE0..0xE7 share this upper prefix
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef logic [CODE_W-1:0] key_t;

  typedef struct packed {
    logic load;   // capture the accepted word
    logic apply;  // apply an add or remove edit
    logic emit;   // load the output report registers
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_commit;
  } dp_status_t;

endpackage

// ===== rtl/hkrb_in_if.sv =====
// ----------------------------------------------------------------------------
// HID key report builder input channel
// Valid/ready channel carrying one key event word.
// ----------------------------------------------------------------------------
interface hkrb_in_if;
  logic                       valid;
  logic                       ready;
  logic [hkrb_pkg::FUNC_W-1:0] func;
  logic [hkrb_pkg::CODE_W-1:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

// ===== rtl/hkrb_out_if.sv =====
// ----------------------------------------------------------------------------
// HID key report builder result channel
// Valid/ready channel carrying one boot report and one NKRO report.
// ----------------------------------------------------------------------------
interface hkrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [hkrb_pkg::BOOT_W-1:0] boot_report;
  logic [hkrb_pkg::MODS_W-1:0] nkro_modifiers;
  logic [hkrb_pkg::HALF_W-1:0] nkro_keys_low;
  logic [hkrb_pkg::HALF_W-1:0] nkro_keys_high;

  modport source (output valid, output boot_report, output nkro_modifiers,
                  output nkro_keys_low, output nkro_keys_high, input ready);
  modport sink   (input valid, input boot_report, input nkro_modifiers,
                  input nkro_keys_low, input nkro_keys_high, output ready);
endinterface

// ===== rtl/hkrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// HID key report builder controller
// Sequences capture, edit and report emission; owns the output valid flag.
// ----------------------------------------------------------------------------
module hkrb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hkrb_pkg::dp_status_t status,
  output hkrb_pkg::ctrl_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_commit) begin
          // hold until the previous report word has left
          if (slot_free) begin
            cmd.emit      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/hkrb_datapath.sv =====
// ----------------------------------------------------------------------------
// HID key report builder datapath
// Holds the pending boot slots, modifiers and NKRO bitmap, and the report
// output registers.
// ----------------------------------------------------------------------------
module hkrb_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hkrb_pkg::FUNC_W-1:0]   in_func,
  input  logic [hkrb_pkg::CODE_W-1:0]   in_key_code,
  input  hkrb_pkg::ctrl_cmd_t           cmd,
  output hkrb_pkg::dp_status_t          status,
  output logic [hkrb_pkg::BOOT_W-1:0]   out_boot_report,
  output logic [hkrb_pkg::MODS_W-1:0]   out_nkro_modifiers,
  output logic [hkrb_pkg::HALF_W-1:0]   out_nkro_keys_low,
  output logic [hkrb_pkg::HALF_W-1:0]   out_nkro_keys_high
);

  localparam int NS   = hkrb_pkg::ROLLOVER_SLOTS;
  localparam int LAST = hkrb_pkg::ROLLOVER_SLOTS - 1;

  logic [hkrb_pkg::FUNC_W-1:0]    item_func_r;
  hkrb_pkg::key_t                 item_code_r;
  logic [hkrb_pkg::MODS_W-1:0]    mods_r, mods_nxt;
  hkrb_pkg::key_t                 slots_r [NS];
  hkrb_pkg::key_t                 slots_nxt [NS];
  logic [hkrb_pkg::NKRO_BITS-1:0] bitmap_r, bitmap_nxt;

  logic [hkrb_pkg::BOOT_W-1:0]    rep_boot_r;
  logic [hkrb_pkg::MODS_W-1:0]    rep_mods_r;
  logic [hkrb_pkg::NKRO_BITS-1:0] rep_bitmap_r;

  hkrb_pkg::key_t ins_slots [NS];
  hkrb_pkg::key_t rem_slots [NS];
  logic [NS-1:0]  gt;
  logic [NS-1:0]  seen;
  logic           present;
  logic           is_mod;
  logic           is_add;
  logic           is_edit;
  logic           in_range;
  logic [hkrb_pkg::BOOT_W-1:0] boot_word;

  assign status.is_commit = (item_func_r == hkrb_pkg::FUNC_COMMIT);

  assign is_mod   = (item_code_r[7:3] == hkrb_pkg::MOD_PREFIX);
  assign is_add   = (item_func_r == hkrb_pkg::FUNC_ADD);
  // only add and remove edit the pending state; the unused code is dropped
  assign is_edit  = is_add || (item_func_r == hkrb_pkg::FUNC_REMOVE);
  assign in_range = (item_code_r < hkrb_pkg::CODE_W'(hkrb_pkg::NKRO_LIMIT));

  // Sorted insert and shift-left removal, one comparator per slot
  always_comb begin
    logic           prev_gt;
    hkrb_pkg::key_t prev_s;
    logic           acc;
    hkrb_pkg::key_t next_s;
    present = 1'b0;
    prev_gt = 1'b0;
    prev_s  = '0;
    acc     = 1'b0;
    next_s  = '0;
    for (int i = 0; i < NS; i++) begin
      // empty slots sit at the top and count as larger than any key
      gt[i]   = (slots_r[i] == '0) || (slots_r[i] > item_code_r);
      present = present || (slots_r[i] == item_code_r);
      acc     = acc || (slots_r[i] == item_code_r);
      seen[i] = acc;
      if (!gt[i]) begin
        ins_slots[i] = slots_r[i];
      end else if (!prev_gt) begin
        ins_slots[i] = item_code_r;
      end else begin
        ins_slots[i] = prev_s;
      end
      prev_gt = gt[i];
      prev_s  = slots_r[i];
    end
    for (int i = LAST; i >= 0; i--) begin
      rem_slots[i] = seen[i] ? next_s : slots_r[i];
      next_s       = slots_r[i];
    end
  end

  always_comb begin
    mods_nxt   = mods_r;
    slots_nxt  = slots_r;
    bitmap_nxt = bitmap_r;
    if (cmd.apply && is_edit) begin
      if (is_mod) begin
        mods_nxt[item_code_r[2:0]] = is_add;
      end else begin
        if (item_code_r != '0) begin
          if (is_add) begin
            if ((slots_r[LAST] == '0) && !present) begin
              slots_nxt = ins_slots;
            end
          end else if (item_func_r == hkrb_pkg::FUNC_REMOVE) begin
            slots_nxt = rem_slots;
          end
        end
        if (in_range && ((item_func_r == hkrb_pkg::FUNC_ADD) ||
                         (item_func_r == hkrb_pkg::FUNC_REMOVE))) begin
          for (int b = 0; b < hkrb_pkg::NKRO_BITS; b++) begin
            if (item_code_r == hkrb_pkg::CODE_W'(b)) begin
              bitmap_nxt[b] = is_add;
            end
          end
        end
      end
    end
  end

  // Boot report: modifiers, reserved zero byte, emitted key slots
  always_comb begin
    boot_word       = '0;
    boot_word[7:0]  = mods_r;
    for (int i = 0; i < hkrb_pkg::BOOT_EMIT_SLOTS; i++) begin
      boot_word[8*(i+2) +: 8] = slots_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func_r <= in_func;
      item_code_r <= in_key_code;
    end
    if (cmd.emit) begin
      rep_boot_r   <= boot_word;
      rep_mods_r   <= mods_r;
      rep_bitmap_r <= bitmap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r   <= '0;
      bitmap_r <= '0;
      for (int i = 0; i < NS; i++) begin
        slots_r[i] <= '0;
      end
    end else begin
      mods_r   <= mods_nxt;
      bitmap_r <= bitmap_nxt;
      slots_r  <= slots_nxt;
    end
  end

  assign out_boot_report    = rep_boot_r;
  assign out_nkro_modifiers = rep_mods_r;
  assign out_nkro_keys_low  = rep_bitmap_r[hkrb_pkg::BITMAP_HALF-1:0];
  assign out_nkro_keys_high = rep_bitmap_r[hkrb_pkg::NKRO_BITS-1:hkrb_pkg::BITMAP_HALF];

endmodule

// ===== rtl/hid_key_report_builder_core.sv =====
// ----------------------------------------------------------------------------
// HID key report builder core
// Builds pending boot (6KRO) and NKRO keyboard reports from key event words.
// ----------------------------------------------------------------------------
// Each event word is captured in the idle state, then applied in the slot
// and bitmap datapath in the execute state; a new word is not taken before
// the last one is through. A commit waits in the execute state while the
// previous report word is still held in the output register; otherwise the
// input side never waits on the result side. Add and remove words produce
// no result; a commit produces one result word with the boot report and the
// NKRO report and leaves the pending state in place. Function code 3 is
// consumed and does nothing. Reset clears all pending state.
// ----------------------------------------------------------------------------
module hid_key_report_builder_core (
  input  logic       clk,
  input  logic       rst_n,
  hkrb_in_if.sink    in_chan,
  hkrb_out_if.source out_chan
);

  hkrb_pkg::ctrl_cmd_t  cmd;
  hkrb_pkg::dp_status_t status;

  // Controller: accept words, sequence edits, hold the result valid flag
  hkrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: pending reports and output report registers
  hkrb_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_chan.func),
    .in_key_code        (in_chan.key_code),
    .cmd                (cmd),
    .status             (status),
    .out_boot_report    (out_chan.boot_report),
    .out_nkro_modifiers (out_chan.nkro_modifiers),
    .out_nkro_keys_low  (out_chan.nkro_keys_low),
    .out_nkro_keys_high (out_chan.nkro_keys_high)
  );

endmodule

// ===== rtl/hkrb_checker.sv =====
// ----------------------------------------------------------------------------
// HID key report builder port checker
// Watches the top-level ports for handshake and sequencing rules.
// ----------------------------------------------------------------------------
`include "hid_key_report_builder_core_defines.svh"

module hkrb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hkrb_pkg::BOOT_W-1:0] out_boot_report,
  input logic [hkrb_pkg::HALF_W-1:0] out_nkro_keys_low
);

  `HKRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `HKRB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_boot_report) && $stable(out_nkro_keys_low))
  `HKRB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `HKRB_ASSERT_NEXT_ANY(a_reset_clears, !rst_n, !out_valid)

endmodule

bind hid_key_report_builder_core hkrb_checker u_hkrb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_boot_report   (out_chan.boot_report),
  .out_nkro_keys_low (out_chan.nkro_keys_low)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// HID key report builder regression
// Drives key event words into the core, mirrors the pending boot and NKRO
// reports, and checks every report word that a commit returns. A short table
// of events comes first, then random typing sessions with bursty input
// and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hkrb_pkg::*;

  localparam int                SLOTS        = ROLLOVER_SLOTS;
  localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;  // unused code, consumed silently
  localparam key_t              MOD_FIRST    = 8'hE0;
  localparam key_t              MOD_LAST     = 8'hE7;
  localparam int                PLAN_ROWS    = 24;
  localparam int                RANDOM_WORDS = 1826;
  localparam int                POOL_KEYS    = 10;
  localparam int                DRAIN_EVERY  = 400;
  localparam int                SETTLE_CYCLES = 12;
  localparam int                IDLE_LIMIT   = 500;

  // One report word as the result channel carries it
  typedef struct packed {
    logic [BOOT_W-1:0] boot;
    logic [MODS_W-1:0] mods;
    logic [HALF_W-1:0] keys_low;
    logic [HALF_W-1:0] keys_high;
  } report_t;

  // One row of the directed plan; pinned rows carry a hand-written report
  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    key_t              code;
    logic              pinned;
    report_t           rep;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hkrb_in_if  in_chan ();
  hkrb_out_if out_chan ();

  hid_key_report_builder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Mirror of the pending reports
  // --------------------------------------------------------------------------
  logic [MODS_W-1:0] boot_mods_q;
  key_t              slots_q [SLOTS];
  logic [MODS_W-1:0] nkro_mods_q;
  logic [HALF_W-1:0] bitmap_q [2];

  report_t reports_due [$];
  int      errors      = 0;
  int      idle_cycles = 0;

  // Sideband that travels with each driven word, so the monitor sees the
  // pinned report of a directed commit at the very edge that accepts it.
  logic    pin_exp = 1'b0;
  report_t pin_rep = '0;

  function automatic void clear_pending_keys();
    boot_mods_q = '0;
    nkro_mods_q = '0;
    foreach (slots_q[i]) slots_q[i] = '0;
    bitmap_q[0] = '0;
    bitmap_q[1] = '0;
  endfunction

  // Apply one add or remove word to the mirrored state
  function automatic void edit_pending_keys(logic [FUNC_W-1:0] fn, key_t code);
    logic [MODS_W-1:0] mbit;
    logic              press;
    bit                done;
    int                i;
    int                j;
    if (fn != FUNC_ADD && fn != FUNC_REMOVE) return;
    press = (fn == FUNC_ADD);
    done  = 1'b0;
    if (code >= MOD_FIRST && code <= MOD_LAST) begin
      // Modifiers only touch the modifier bytes of both reports
      mbit = 8'h01 << (code - MOD_FIRST);
      if (press) begin
        boot_mods_q = boot_mods_q | mbit;
        nkro_mods_q = nkro_mods_q | mbit;
      end else begin
        boot_mods_q = boot_mods_q & ~mbit;
        nkro_mods_q = nkro_mods_q & ~mbit;
      end
      return;
    end
    if (code != '0) begin
      if (press && slots_q[SLOTS-1] == '0) begin
        // Sorted insert; a key already held stays single
        for (i = 0; i < SLOTS && !done; i++) begin
          if (slots_q[i] == code) begin
            done = 1'b1;
          end else if (slots_q[i] == '0) begin
            slots_q[i] = code;
            done = 1'b1;
          end else if (slots_q[i] > code) begin
            for (j = SLOTS - 1; j > i; j--) slots_q[j] = slots_q[j-1];
            slots_q[i] = code;
            done = 1'b1;
          end
        end
      end else if (!press) begin
        // Close the gap left by the released key
        for (i = 0; i < SLOTS && !done; i++) begin
          if (slots_q[i] == code) begin
            for (j = i + 1; j < SLOTS; j++) slots_q[j-1] = slots_q[j];
            slots_q[SLOTS-1] = '0;
            done = 1'b1;
          end
        end
      end
    end
    if (int'(code) < NKRO_LIMIT) begin
      bitmap_q[int'(code) / BITMAP_HALF][int'(code) % BITMAP_HALF] = press;
    end
  endfunction

  function automatic report_t pending_report();
    report_t rep;
    int      i;
    rep      = '0;
    rep.boot[7:0] = boot_mods_q;
    for (i = 0; i < BOOT_EMIT_SLOTS; i++) rep.boot[8*(i+2) +: 8] = slots_q[i];
    rep.mods      = nkro_mods_q;
    rep.keys_low  = bitmap_q[0];
    rep.keys_high = bitmap_q[1];
    return rep;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check returned report words, advance the mirror on each
  // accepted event word, and watch for a stuck channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    report_t due;
    report_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        got   = '{out_chan.boot_report, out_chan.nkro_modifiers,
                  out_chan.nkro_keys_low, out_chan.nkro_keys_high};
        if (reports_due.size() == 0) begin
          $error("report word returned with no commit outstanding");
          errors++;
        end else begin
          due = reports_due.pop_front();
          check_field("boot_report", due.boot, got.boot);
          check_field("nkro_modifiers", 64'(due.mods), 64'(got.mods));
          check_field("nkro_keys_low", 64'(due.keys_low), 64'(got.keys_low));
          check_field("nkro_keys_high", 64'(due.keys_high), 64'(got.keys_high));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        moved = 1'b1;
        if (in_chan.func == FUNC_COMMIT) begin
          reports_due.push_back(pin_exp ? pin_rep : pending_report());
        end else begin
          edit_pending_keys(in_chan.func, in_chan.key_code);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready follows a rotating 16-bit pattern that is reloaded
  // periodically at random; bit 0 is forced so every pattern has a ready bit.
  // --------------------------------------------------------------------------
  initial begin : result_stall
    logic [15:0] pattern;
    int          age;
    out_chan.ready = 1'b0;
    pattern = 16'hFFFF;
    age     = 0;
    forever begin
      @(posedge clk);
      if (age == 63) begin
        case ($urandom_range(0, 3))
          0:       pattern = 16'hFFFF;
          1:       pattern = 16'($urandom() & $urandom()) | 16'h0001;
          default: pattern = 16'($urandom()) | 16'h0001;
        endcase
        age = 0;
      end else begin
        age++;
      end
      out_chan.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  // --------------------------------------------------------------------------
  // Event side
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // Offer one word and hold it until the core takes it; at the end of a
  // burst, drop valid and idle for a random gap with junk on the payload.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input key_t code,
                           input logic pinned = 1'b0, input report_t pinned_rep = '0);
    int gap;
    in_chan.valid    <= 1'b1;
    in_chan.func     <= fn;
    in_chan.key_code <= code;
    pin_exp          <= pinned;
    pin_rep          <= pinned_rep;
    do @(posedge clk); while (!in_chan.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_chan.valid    <= 1'b0;
      in_chan.func     <= FUNC_W'($urandom());
      in_chan.key_code <= CODE_W'($urandom());
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 40);
    end
  endtask

  // Hold the input off until every outstanding report word is back
  task automatic wait_reports_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Codes that sit on the interesting boundaries, plus plain random ones
  function automatic key_t pick_code();
    case ($urandom_range(0, 9))
      0:       return MOD_FIRST + key_t'($urandom_range(0, 7));
      1:       return '0;
      2:       return key_t'($urandom_range(NKRO_LIMIT - 2, NKRO_LIMIT + 1));
      3:       return key_t'($urandom_range(BITMAP_HALF - 2, BITMAP_HALF + 1));
      4:       return key_t'($urandom_range(232, 255));
      5:       return key_t'($urandom_range(0, 255));
      default: return key_t'($urandom_range(1, 127));
    endcase
  endfunction

  // Directed events; only the reset commit and the modifier-only commit
  // carry a hand-written report, the rest follow the mirror.
  plan_row_t key_plan [PLAN_ROWS] = '{
    '{FUNC_COMMIT, 8'h00, 1'b1, '{64'h0, 8'h00, 60'h0, 60'h0}},  // empty after reset
    '{FUNC_ADD,    8'hE0, 1'b0, '0},                              // lowest modifier
    '{FUNC_ADD,    8'hE7, 1'b0, '0},                              // highest modifier
    '{FUNC_COMMIT, 8'hFF, 1'b1, '{64'h81, 8'h81, 60'h0, 60'h0}},
    '{FUNC_ADD,    8'h00, 1'b0, '0},  // code zero: NKRO bit 0 only
    '{FUNC_ADD,    8'hFF, 1'b0, '0},  // boot slot only, past NKRO range
    '{FUNC_ADD,    8'h3C, 1'b0, '0},  // first bit of the upper half
    '{FUNC_ADD,    8'h3B, 1'b0, '0},  // last bit of the lower half
    '{FUNC_ADD,    8'h77, 1'b0, '0},  // last NKRO bit
    '{FUNC_ADD,    8'h78, 1'b0, '0},  // first code past NKRO range
    '{FUNC_ADD,    8'h3C, 1'b0, '0},  // duplicate add
    '{FUNC_COMMIT, 8'h00, 1'b0, '0},
    '{FUNC_ADD,    8'h04, 1'b0, '0},  // insert at the front, fills the slots
    '{FUNC_ADD,    8'h05, 1'b0, '0},  // slots full: dropped from boot
    '{FUNC_ADD,    8'h04, 1'b0, '0},  // full and already present
    '{FUNC_NONE,   8'hE7, 1'b0, '0},  // unused function code on a held modifier
    '{FUNC_COMMIT, 8'hA5, 1'b0, '0},
    '{FUNC_REMOVE, 8'h3C, 1'b0, '0},  // release from the middle
    '{FUNC_REMOVE, 8'h50, 1'b0, '0},  // release of an absent key
    '{FUNC_REMOVE, 8'h00, 1'b0, '0},  // code zero release
    '{FUNC_REMOVE, 8'hE0, 1'b0, '0},
    '{FUNC_COMMIT, 8'h00, 1'b0, '0},
    '{FUNC_REMOVE, 8'hFF, 1'b0, '0},  // release of the last slot
    '{FUNC_COMMIT, 8'h00, 1'b0, '0}
  };

  initial begin : stimulus
    key_t key_pool [POOL_KEYS];
    int   session_left;
    int   sent;
    int   roll;
    clear_pending_keys();
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.func     = FUNC_ADD;
    in_chan.key_code = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (key_plan[r]) begin
      send_word(key_plan[r].fn, key_plan[r].code, key_plan[r].pinned, key_plan[r].rep);
    end
    wait_reports_drained();

    // Typing sessions: a small pool of keys pressed and released at random,
    // committed now and then, with some noise words mixed in.
    session_left = 0;
    sent         = 0;
    while (sent < RANDOM_WORDS) begin
      if (session_left == 0) begin
        foreach (key_pool[k]) key_pool[k] = pick_code();
        session_left = $urandom_range(30, 80);
      end
      session_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_word(FUNC_NONE, key_t'($urandom_range(0, 255)));
      end else begin
        if (roll < 48) begin
          send_word(FUNC_ADD, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
        end else if (roll < 83) begin
          send_word(FUNC_REMOVE, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
        end else if (roll < 95) begin
          send_word(FUNC_COMMIT, key_t'($urandom_range(0, 255)));
        end else begin
          send_word($urandom_range(0, 1) ? FUNC_ADD : FUNC_REMOVE,
                    key_t'($urandom_range(0, 255)));
        end
        sent++;
        if (sent % DRAIN_EVERY == 0) wait_reports_drained();
      end
    end

    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
